>>> rtl/cshb_pkg.sv
// Package: types, constants and symbol mapping for the base-38 callsign hash.
package cshb_pkg;

    localparam int ACC_W  = 64;
    localparam int CNT_W  = 4;
    localparam int BYTE_W = 8;
    localparam int SYM_W  = 6;
    localparam int H22_W  = 22;
    localparam int H12_W  = 12;
    localparam int H10_W  = 10;
    localparam int HALF_W = 32;

    localparam logic [35:0] HASH_MULT = 36'd47055833459;
    localparam logic [HALF_W-1:0] HASH_MULT_LO = HASH_MULT[31:0];
    localparam logic [3:0]        HASH_MULT_HI = HASH_MULT[35:32];

    localparam logic [SYM_W-1:0] SYM_SPACE = 6'd0;
    localparam logic [SYM_W-1:0] SYM_DIGIT = 6'd1;
    localparam logic [SYM_W-1:0] SYM_ALPHA = 6'd11;
    localparam logic [SYM_W-1:0] SYM_SLASH = 6'd37;

    typedef struct packed {
        logic [ACC_W-1:0] acc;
        logic [CNT_W-1:0] count;
    } job_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_PAD,
        B_MUL_LO,
        B_MUL_HI,
        B_FIN
    } back_state_t;

    function automatic logic [SYM_W-1:0] sym_of(input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] c;
        logic [SYM_W-1:0]  s;
        c = b;
        if (c inside {[8'h61:8'h7A]})
            c = c - 8'h20;
        if (c inside {[8'h30:8'h39]})
            s = SYM_DIGIT + SYM_W'(c - 8'h30);
        else if (c inside {[8'h41:8'h5A]})
            s = SYM_ALPHA + SYM_W'(c - 8'h41);
        else if (c == 8'h2F)
            s = SYM_SLASH;
        else
            s = SYM_SPACE;
        return s;
    endfunction

    function automatic logic [ACC_W-1:0] times38(input logic [ACC_W-1:0] v);
        return (v << 5) + (v << 2) + (v << 1);
    endfunction

endpackage

>>> rtl/cshb_char_if.sv
// Interface: character input channel.
interface cshb_char_if
    import cshb_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] char_byte;
    logic              last_char;

    modport source (output valid, output char_byte, output last_char, input ready);
    modport sink   (input valid, input char_byte, input last_char, output ready);
endinterface

>>> rtl/cshb_hash_if.sv
// Interface: hash result channel.
interface cshb_hash_if
    import cshb_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [H22_W-1:0] hash22;
    logic [H12_W-1:0] hash12;
    logic [H10_W-1:0] hash10;

    modport source (output valid, output hash22, output hash12, output hash10, input ready);
    modport sink   (input valid, input hash22, input hash12, input hash10, output ready);
endinterface

>>> rtl/callsign_hash_base38_unit.sv
// Top level of the base-38 callsign hash unit.
// Characters are taken one per cycle while the queue has room; each callsign's
// base-38 value enters a two-entry queue on its last character. The back end then
// fetches each callsign, pads it by one multiply by 38 per missing symbol plus a
// check, runs the split 64-by-36-bit constant multiply built from 32x32 partial
// products in its low and high halves, and loads the output register. The front
// stalls only while the queue holds two callsigns; the result waits in its own
// register until taken.
module callsign_hash_base38_unit
    import cshb_pkg::*;
#(
    parameter int FIELD_CHARS = 11
)(
    input  logic        clk,
    input  logic        rst_n,
    cshb_char_if.sink   char_in,
    cshb_hash_if.source hash_out
);

    logic q_full;
    logic q_empty;
    logic q_push;
    logic q_pop;
    job_t push_job;
    job_t pop_job;

    cshb_front #(.FIELD_CHARS(FIELD_CHARS)) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .char_in (char_in),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_job   (push_job)
    );

    cshb_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (q_pop),
        .pop_job  (pop_job),
        .empty    (q_empty)
    );

    cshb_back #(.FIELD_CHARS(FIELD_CHARS)) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_job    (pop_job),
        .q_pop    (q_pop),
        .hash_out (hash_out)
    );

endmodule

>>> rtl/cshb_front.sv
// Front end: takes characters, folds them to symbols and builds the base-38 value.
module cshb_front
    import cshb_pkg::*;
#(
    parameter int FIELD_CHARS = 11
)(
    input  logic             clk,
    input  logic             rst_n,
    cshb_char_if.sink        char_in,
    input  logic             q_full,
    output logic             q_push,
    output job_t             q_job
);

    logic [ACC_W-1:0] acc_reg, acc_next, acc_upd;
    logic [CNT_W-1:0] cnt_reg, cnt_next, cnt_upd;
    logic             ended_reg, ended_next, ended_upd;
    logic             accept;
    logic             take;
    logic             zero_byte;

    assign char_in.ready = !q_full;
    assign accept        = char_in.valid && char_in.ready;
    assign zero_byte     = (char_in.char_byte == '0);

    always_comb
    begin
        take      = !ended_reg && !zero_byte && (cnt_reg < CNT_W'(FIELD_CHARS));
        acc_upd   = take ? times38(acc_reg) + ACC_W'(sym_of(char_in.char_byte)) : acc_reg;
        cnt_upd   = take ? cnt_reg + 1'b1 : cnt_reg;
        ended_upd = ended_reg || zero_byte;

        acc_next   = acc_reg;
        cnt_next   = cnt_reg;
        ended_next = ended_reg;
        if (accept)
        begin
            if (char_in.last_char)
            begin
                acc_next   = '0;
                cnt_next   = '0;
                ended_next = 1'b0;
            end
            else
            begin
                acc_next   = acc_upd;
                cnt_next   = cnt_upd;
                ended_next = ended_upd;
            end
        end
    end

    assign q_push    = accept && char_in.last_char;
    assign q_job.acc   = acc_upd;
    assign q_job.count = cnt_upd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg   <= '0;
            cnt_reg   <= '0;
            ended_reg <= 1'b0;
        end
        else
        begin
            acc_reg   <= acc_next;
            cnt_reg   <= cnt_next;
            ended_reg <= ended_next;
        end
    end

endmodule

>>> rtl/cshb_queue.sv
// Two-entry queue of finished callsign values between front and back.
module cshb_queue
    import cshb_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output job_t pop_job,
    output logic empty
);

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int FILL_W = $clog2(DEPTH + 1);

    job_t              mem [DEPTH];
    logic [PTR_W-1:0]  wr_reg, wr_next;
    logic [PTR_W-1:0]  rd_reg, rd_next;
    logic [FILL_W-1:0] fill_reg, fill_next;

    assign full    = (fill_reg == FILL_W'(DEPTH));
    assign empty   = (fill_reg == '0);
    assign pop_job = mem[rd_reg];

    always_comb
    begin
        wr_next   = push ? wr_reg + 1'b1 : wr_reg;
        rd_next   = pop ? rd_reg + 1'b1 : rd_reg;
        fill_next = fill_reg + FILL_W'(push) - FILL_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg   <= '0;
            rd_reg   <= '0;
            fill_reg <= '0;
        end
        else
        begin
            wr_reg   <= wr_next;
            rd_reg   <= rd_next;
            fill_reg <= fill_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
        else $error("queue push while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) !(pop && empty))
        else $error("queue pop while empty");

endmodule

>>> rtl/cshb_back.sv
// Back end: pads the value, multiplies by the hash constant and holds the result.
module cshb_back
    import cshb_pkg::*;
#(
    parameter int FIELD_CHARS = 11
)(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_empty,
    input  job_t          q_job,
    output logic          q_pop,
    cshb_hash_if.source   hash_out
);

    back_state_t       state_reg, state_next;
    logic [ACC_W-1:0]  n_reg, n_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [ACC_W-1:0]  lo_reg, lo_next;
    logic [HALF_W-1:0] hi_reg, hi_next;
    logic              out_valid_reg, out_valid_next;
    logic [H22_W-1:0]  h22_reg, h22_next;
    logic              load_out;
    logic [HALF_W-1:0] top_sum;
    logic [HALF_W-1:0] prod_hh;
    logic [HALF_W-1:0] prod_lh;

    assign top_sum = lo_reg[ACC_W-1:HALF_W] + hi_reg;
    assign prod_hh = n_reg[ACC_W-1:HALF_W] * HASH_MULT_LO;
    assign prod_lh = n_reg[HALF_W-1:0] * HALF_W'(HASH_MULT_HI);

    always_comb
    begin
        state_next     = state_reg;
        n_next         = n_reg;
        cnt_next       = cnt_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        h22_next       = h22_reg;
        q_pop          = 1'b0;
        load_out       = 1'b0;
        out_valid_next = out_valid_reg && !hash_out.ready;
        case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    n_next     = q_job.acc;
                    cnt_next   = q_job.count;
                    state_next = B_PAD;
                end
            end
            B_PAD:
            begin
                if (cnt_reg >= CNT_W'(FIELD_CHARS))
                    state_next = B_MUL_LO;
                else
                begin
                    n_next   = times38(n_reg);
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            B_MUL_LO:
            begin
                lo_next    = n_reg[HALF_W-1:0] * HASH_MULT_LO;
                state_next = B_MUL_HI;
            end
            B_MUL_HI:
            begin
                hi_next    = prod_hh + prod_lh;
                state_next = B_FIN;
            end
            B_FIN:
            begin
                if (!out_valid_reg || hash_out.ready)
                begin
                    load_out       = 1'b1;
                    h22_next       = top_sum[HALF_W-1:HALF_W-H22_W];
                    out_valid_next = 1'b1;
                    state_next     = B_IDLE;
                end
            end
            default:
                state_next = B_IDLE;
        endcase
    end

    assign hash_out.valid  = out_valid_reg;
    assign hash_out.hash22 = h22_reg;
    assign hash_out.hash12 = h22_reg[H22_W-1:H22_W-H12_W];
    assign hash_out.hash10 = h22_reg[H22_W-1:H22_W-H10_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg   <= n_next;
        cnt_reg <= cnt_next;
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
        h22_reg <= h22_next;
    end

    a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> hash_out.valid)
        else $error("result loaded but not presented");
    a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (state_reg == B_IDLE) && !q_empty)
        else $error("queue popped outside idle");
    a_pad_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_MUL_LO) |-> (cnt_reg == CNT_W'(FIELD_CHARS)))
        else $error("padding count wrong at multiply");

endmodule

>>> tb/sv/callsign_hash_base38_check.sv
// Checker for the base-38 callsign hash unit: predicts each hash and compares it on arrival.
`timescale 1ns / 1ps
module callsign_hash_base38_check
    import cshb_pkg::*;
#(
    parameter int FIELD_CHARS = 11
)(
    input  logic  clk,
    input  logic  rst_n,
    cshb_char_if  char_mon,
    cshb_hash_if  hash_mon,
    output int    mismatches,
    output int    awaiting
);

    localparam logic [63:0] HASH_FACTOR = 64'd47055833459;

    typedef struct packed {
        logic [H22_W-1:0] h22;
        logic [H12_W-1:0] h12;
        logic [H10_W-1:0] h10;
    } callsign_hash_t;

    logic [63:0]    base38_value;
    int             symbols_taken;
    logic           name_closed;
    callsign_hash_t hash_expected[$];
    callsign_hash_t oldest;

    function automatic logic [SYM_W-1:0] symbol_code(input logic [BYTE_W-1:0] ch);
        logic [BYTE_W-1:0] up;
        up = ch;
        if (up >= "a" && up <= "z")
            up = up - 8'h20;
        if (up >= "0" && up <= "9")
            return SYM_DIGIT + SYM_W'(up - "0");
        if (up >= "A" && up <= "Z")
            return SYM_ALPHA + SYM_W'(up - "A");
        if (up == "/")
            return SYM_SLASH;
        return SYM_SPACE;
    endfunction

    function automatic callsign_hash_t callsign_hash(input logic [63:0] value, input int taken);
        logic [63:0]    padded;
        logic [63:0]    product;
        callsign_hash_t h;
        padded = value;
        for (int k = taken; k < FIELD_CHARS; k++)
            padded = padded * 64'd38;
        product = padded * HASH_FACTOR;
        h.h22 = product[63:42];
        h.h12 = product[63:52];
        h.h10 = product[63:54];
        return h;
    endfunction

    initial
    begin
        mismatches = 0;
        awaiting   = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base38_value  = '0;
            symbols_taken = 0;
            name_closed   = 1'b0;
        end
        else
        begin
            if (char_mon.valid && char_mon.ready)
            begin
                if (!name_closed)
                begin
                    if (char_mon.char_byte == 8'h00)
                        name_closed = 1'b1;
                    else if (symbols_taken < FIELD_CHARS)
                    begin
                        base38_value  = base38_value * 64'd38
                                        + 64'(symbol_code(char_mon.char_byte));
                        symbols_taken = symbols_taken + 1;
                    end
                end
                if (char_mon.last_char)
                begin
                    hash_expected.push_back(callsign_hash(base38_value, symbols_taken));
                    base38_value  = '0;
                    symbols_taken = 0;
                    name_closed   = 1'b0;
                end
            end
            if (hash_mon.valid && hash_mon.ready)
            begin
                if (hash_expected.size() == 0)
                begin
                    $error("hash item with none pending: hash22 %0h", hash_mon.hash22);
                    mismatches++;
                end
                else
                begin
                    oldest = hash_expected.pop_front();
                    if (hash_mon.hash22 !== oldest.h22)
                    begin
                        $error("hash22 expected %0h actual %0h", oldest.h22, hash_mon.hash22);
                        mismatches++;
                    end
                    if (hash_mon.hash12 !== oldest.h12)
                    begin
                        $error("hash12 expected %0h actual %0h", oldest.h12, hash_mon.hash12);
                        mismatches++;
                    end
                    if (hash_mon.hash10 !== oldest.h10)
                    begin
                        $error("hash10 expected %0h actual %0h", oldest.h10, hash_mon.hash10);
                        mismatches++;
                    end
                end
            end
            awaiting = hash_expected.size();
        end
    end

endmodule

>>> tb/sv/callsign_hash_base38_unit_tb.sv
// Testbench top for the base-38 callsign hash unit: clock, reset, callsign traffic and verdict.
`timescale 1ns / 1ps
module callsign_hash_base38_unit_tb;
    import cshb_pkg::*;

    localparam int FIELD_CHARS = 11;
    localparam int BACKLOG_CYCLES = 300;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    int          sender_idle   = 29;
    int          receiver_idle = 45;
    int          traffic_phase = 0;
    int          chars_sent    = 0;
    int          mismatches;
    int          awaiting;
    logic [7:0]  callsign_bytes[$];

    cshb_char_if char_ch ();
    cshb_hash_if hash_ch ();

    callsign_hash_base38_unit #(
        .FIELD_CHARS (FIELD_CHARS)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .char_in  (char_ch),
        .hash_out (hash_ch)
    );

    callsign_hash_base38_check #(
        .FIELD_CHARS (FIELD_CHARS)
    ) u_hash_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_mon   (char_ch),
        .hash_mon   (hash_ch),
        .mismatches (mismatches),
        .awaiting   (awaiting)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic send_char(input logic [7:0] ch, input logic last);
        while ($urandom_range(99) < sender_idle)
        begin
            char_ch.valid <= 1'b0;
            @(posedge clk);
        end
        char_ch.valid     <= 1'b1;
        char_ch.char_byte <= ch;
        char_ch.last_char <= last;
        @(posedge clk);
        while (!char_ch.ready)
            @(posedge clk);
        chars_sent++;
    endtask

    task automatic send_callsign();
        int n;
        n = callsign_bytes.size();
        for (int i = 0; i < n; i++)
            send_char(callsign_bytes[i], i == n - 1);
    endtask

    function automatic logic [7:0] random_char();
        int r;
        r = $urandom_range(99);
        if (r < 30)
            return 8'h41 + 8'($urandom_range(25));
        if (r < 45)
            return 8'h61 + 8'($urandom_range(25));
        if (r < 65)
            return 8'h30 + 8'($urandom_range(9));
        if (r < 72)
            return "/";
        if (r < 78)
            return " ";
        if (r < 93)
            return 8'($urandom_range(255));
        return 8'h00;
    endfunction

    task automatic random_callsign();
        int len;
        int noise;
        noise = int'($urandom_range(99) < 15);
        if ($urandom_range(99) < 10)
            len = $urandom_range(15, 12);
        else
            len = $urandom_range(8, 1);
        callsign_bytes.delete();
        for (int i = 0; i < len; i++)
            callsign_bytes.push_back((noise != 0) ? 8'($urandom_range(255)) : random_char());
    endtask

    initial
    begin
        hash_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (traffic_phase == 2 && !$isunknown(traffic_phase) && BACKLOG_CYCLES > 0
                && chars_sent < 900)
            begin
                for (int held = 0; held < BACKLOG_CYCLES; held++)
                begin
                    hash_ch.ready <= 1'b0;
                    @(posedge clk);
                end
                while (chars_sent < 900)
                begin
                    hash_ch.ready <= ($urandom_range(99) >= receiver_idle);
                    @(posedge clk);
                end
            end
            else
            begin
                hash_ch.ready <= ($urandom_range(99) >= receiver_idle);
                @(posedge clk);
            end
        end
    end

    initial
    begin
        char_ch.valid     <= 1'b0;
        char_ch.char_byte <= 8'h00;
        char_ch.last_char <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        callsign_bytes = '{8'h00};
        send_callsign();
        callsign_bytes = '{" "};
        send_callsign();
        callsign_bytes = '{8'hFF, "z"};
        send_callsign();
        callsign_bytes = '{"0", "/", "9", "a"};
        send_callsign();
        callsign_bytes = '{"Z", "Z", "Z", "Z", "Z", "Z", "Z", "Z", "Z", "Z", "Z", "Z"};
        send_callsign();
        callsign_bytes = '{"Q", 8'h00, "X", "Y"};
        send_callsign();

        while (chars_sent < 1225)
        begin
            if (chars_sent >= 825)
            begin
                sender_idle   = 0;
                receiver_idle = 0;
                traffic_phase = 2;
            end
            else if (chars_sent >= 425)
            begin
                sender_idle   = 45;
                receiver_idle = 29;
                traffic_phase = 1;
            end
            random_callsign();
            send_callsign();
        end
        char_ch.valid <= 1'b0;

        while (awaiting != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (mismatches == 0 && awaiting == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #3000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

>>> sim.f
rtl/cshb_pkg.sv
rtl/cshb_char_if.sv
rtl/cshb_hash_if.sv
rtl/cshb_front.sv
rtl/cshb_queue.sv
rtl/cshb_back.sv
rtl/callsign_hash_base38_unit.sv
tb/sv/callsign_hash_base38_check.sv
tb/sv/callsign_hash_base38_unit_tb.sv
